### design/ducs_pkg.sv
// ducs_pkg: shared types and constants for the dex/ucs block receiver
// holds the word structs, the receive phase enum and the link control characters
// no dependencies
`timescale 1ns / 1ps

package ducs_pkg;

  // default frame buffer depth
  localparam int unsigned DefaultBufferDepth = 256;

  // buffer limit register reset value
  localparam logic [7:0] LimitReset = 8'hFF;

  // link control characters
  localparam logic [7:0] ChSoh  = 8'h01;
  localparam logic [7:0] ChStx  = 8'h02;
  localparam logic [7:0] ChEtx  = 8'h03;
  localparam logic [7:0] ChEot  = 8'h04;
  localparam logic [7:0] ChEnq  = 8'h05;
  localparam logic [7:0] ChDle  = 8'h10;
  localparam logic [7:0] ChSyn  = 8'h16;
  localparam logic [7:0] ChEtb  = 8'h17;
  // upper seven bits of the ascii '0' / '1' acknowledge characters
  localparam logic [6:0] AckBase = 7'b0011000;

  // item kinds on the input word
  localparam logic ActByte   = 1'b0;
  localparam logic ActTxDone = 1'b1;

  typedef enum logic [2:0] {
    PH_READY  = 3'd0,
    PH_BUSY   = 3'd1,
    PH_CRC_HI = 3'd2,
    PH_CRC_LO = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } rx_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [7:0]  write_index;
    logic [7:0]  write_byte;
    logic [8:0]  byte_count;
    logic [2:0]  rx_phase;
    logic        rx_status;
    logic [5:0]  ack_char;
    logic [15:0] captured_crc;
  } rx_out_t;

endpackage

### design/dex_ucs_block_receiver.sv
// dex_ucs_block_receiver: receive-side framer for the dex/ucs serial link
// one module: framing state, result register and skid stage
// depends on ducs_pkg
`timescale 1ns / 1ps

// Takes one received character (or a transmission-finished event) per input
// word and returns exactly one result word for it: a frame buffer write
// (enable, index, byte) plus the framer status after that character (byte
// count, receive phase, ok/bad status, expected acknowledge character and the
// captured block crc). The whole framing step is a single pass of logic
// between the state registers and the result register, so while in_stall_o
// is low a word is taken on every clock; sustained rate is one word per
// cycle. A two-word output stage (result register plus skid register) keeps
// the input open while a result waits: in_stall_o rises only once both are
// full. The user must write buffer_limit (via cfg_wr_en_i / cfg_wr_data_i)
// only while the block is idle; the block does not enforce this. The limit
// in effect is the smaller of it and BUFFER_DEPTH-1; crc captured, not checked.
module dex_ucs_block_receiver
  import ducs_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DefaultBufferDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: buffer limit
  input  logic       cfg_wr_en_i,
  input  logic [7:0] cfg_wr_data_i,
  // input word channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  rx_in_t     in_data_i,
  // result word channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rx_out_t    out_data_o
);

  // effective ceiling from the buffer depth, clipped to the 8-bit index
  localparam int unsigned DepthTop = (BUFFER_DEPTH - 1 < 255) ? BUFFER_DEPTH - 1 : 255;
  localparam logic [7:0]  DepthLim = 8'(DepthTop);

  // framer state
  phase_e      phase_q, phase_d;
  logic        prev_dle_q, prev_dle_d;   // previous byte was DLE
  logic        seq_q, seq_d;             // low bit of expected ack character
  logic [8:0]  count_q, count_d;
  logic        status_q, status_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  limit_q;

  // output stage
  logic        out_valid_q;
  rx_out_t     out_word_q;
  logic        skid_valid_q;
  rx_out_t     skid_word_q;

  logic        in_take;
  logic        out_pop;
  logic [7:0]  eff_limit;
  logic        room;
  logic [7:0]  d;
  logic        we;
  logic [7:0]  widx;
  logic [7:0]  wbyte;
  rx_out_t     result;

  assign in_stall_o  = skid_valid_q;
  assign in_take     = in_valid_i & ~skid_valid_q;
  assign out_pop     = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  assign eff_limit = (limit_q > DepthLim) ? DepthLim : limit_q;
  // a byte may still be stored while count has not passed the limit
  assign room      = (count_q <= {1'b0, eff_limit});
  assign d         = in_data_i.rx_byte;

  // one framing step
  always_comb begin
    phase_d    = phase_q;
    prev_dle_d = prev_dle_q;
    seq_d      = seq_q;
    count_d    = count_q;
    status_d   = status_q;
    crc_d      = crc_q;
    we         = 1'b0;
    widx       = '0;
    wbyte      = '0;

    if (in_data_i.action == ActTxDone) begin
      // transmission finished: back to ready, nothing else moves
      phase_d = PH_READY;
    end else begin
      case (phase_q)
        PH_CRC_HI: begin
          crc_d   = {d, 8'h00};
          phase_d = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_d   = {crc_q[15:8], d};
          phase_d = PH_DONE;
        end
        PH_BUSY: begin
          if (!prev_dle_q) begin
            // plain data, a DLE inside data included
            if (room) begin
              we      = 1'b1;
              widx    = count_q[7:0];
              wbyte   = d;
              count_d = count_q + 9'd1;
            end
          end else if (d == ChSoh || d == ChStx) begin
            // block opens
            we      = 1'b1;
            wbyte   = d;
            count_d = 9'd1;
          end else if (d == {AckBase, seq_q}) begin
            // sequence acknowledge
            we       = 1'b1;
            wbyte    = d;
            count_d  = 9'd1;
            seq_d    = ~seq_q;
            phase_d  = PH_DONE;
            status_d = 1'b0;
          end else if (d == ChEtx || d == ChEtb) begin
            // end of block, crc follows
            if (room) begin
              we      = 1'b1;
              widx    = count_q[7:0];
              wbyte   = d;
              count_d = count_q + 9'd1;
            end
            phase_d = PH_CRC_HI;
          end else if (d != ChSyn) begin
            // unknown DLE pair
            phase_d  = PH_DONE;
            status_d = 1'b1;
          end
        end
        default: begin
          // ready, done
          if (d == ChEot || d == ChEnq) begin
            we       = 1'b1;
            wbyte    = d;
            count_d  = 9'd1;
            seq_d    = 1'b0;
            phase_d  = PH_DONE;
            status_d = 1'b0;
          end else if (d == ChDle) begin
            phase_d = PH_BUSY;
            count_d = '0;
          end
        end
      endcase
      prev_dle_d = (d == ChDle);
    end
  end

  always_comb begin
    result.write_enable = we;
    result.write_index  = widx;
    result.write_byte   = wbyte;
    result.byte_count   = count_d;
    result.rx_phase     = phase_d;
    result.rx_status    = status_d;
    result.ack_char     = {AckBase[4:0], seq_d};
    result.captured_crc = crc_d;
  end

  // framer state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_READY;
      prev_dle_q <= 1'b0;
      seq_q      <= 1'b0;
      count_q    <= '0;
      status_q   <= 1'b0;
      crc_q      <= '0;
      limit_q    <= LimitReset;
    end else begin
      if (cfg_wr_en_i) begin
        limit_q <= cfg_wr_data_i;
      end
      if (in_take) begin
        phase_q    <= phase_d;
        prev_dle_q <= prev_dle_d;
        seq_q      <= seq_d;
        count_q    <= count_d;
        status_q   <= status_d;
        crc_q      <= crc_d;
      end
    end
  end

  // output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_take) begin
        if (out_valid_q && !out_pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_word_q <= skid_word_q;
      end
    end else if (in_take) begin
      if (out_valid_q && !out_pop) begin
        skid_word_q <= result;
      end else begin
        out_word_q <= result;
      end
    end
  end

endmodule

### design/ducs_checker.sv
// ducs_checker: port-level checks for dex_ucs_block_receiver
// bound to the top level below; depends on ducs_pkg
`timescale 1ns / 1ps

module ducs_checker
  import ducs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input rx_out_t    out_data_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // a written index always lies below the count that follows it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_enable |->
      {1'b0, out_data_o.write_index} < out_data_o.byte_count)
    else $error("write index not below byte count");

  // no write leaves index and byte at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_enable |->
      out_data_o.write_index == 8'd0 && out_data_o.write_byte == 8'd0)
    else $error("idle write fields not zero");

  // acknowledge character is ascii zero or one, count within buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.ack_char == 6'h30 || out_data_o.ack_char == 6'h31)
      && out_data_o.byte_count <= 9'd256)
    else $error("ack character or byte count out of range");

endmodule

bind dex_ucs_block_receiver ducs_checker u_ducs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### dv/tb_dex_ucs_block_receiver.sv
`timescale 1ns / 1ps
// tb_dex_ucs_block_receiver: self-checking bench for the dex/ucs block receiver
// feeds framed character streams, predicts each result word and checks them in order
// depends on ducs_pkg and dex_ucs_block_receiver

module tb_dex_ucs_block_receiver;
  import ducs_pkg::*;

  localparam int TotalWords    = 1250;
  localparam int CalmFrom      = TotalWords - 150;  // no idling from here on
  localparam int WatchdogLimit = 2000;
  localparam int LongHold      = 80;
  localparam logic [7:0] AckZero = {AckBase, 1'b0};
  localparam logic [7:0] AckOne  = {AckBase, 1'b1};

  // one row of the directed stimulus: the word and, where obvious, its result
  typedef struct packed {
    rx_in_t  word;
    logic    typed;
    rx_out_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  rx_in_t     in_data;
  logic       out_valid;
  logic       out_stall;
  rx_out_t    out_data;

  always #5 clk = ~clk;

  dex_ucs_block_receiver #(
    .BUFFER_DEPTH(DefaultBufferDepth)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_wr_en_i  (cfg_wr_en),
    .cfg_wr_data_i(cfg_wr_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_data_i    (in_data),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_o   (out_data)
  );

  // framer state as the bench sees it
  phase_e      pr_phase;
  logic [7:0]  pr_prev;
  logic [7:0]  pr_seq;
  logic [8:0]  pr_count;
  logic        pr_bad;
  logic [15:0] pr_crc;
  logic [7:0]  pr_limit;

  rx_out_t   framer_results_q[$];
  stim_row_t directed_q[$];

  int  fail_count   = 0;
  int  words_sent   = 0;
  int  results_seen = 0;
  int  gap_pct      = 10;
  bit  calm         = 1'b0;
  bit  hold_req     = 1'b0;
  int  input_stalls = 0;
  int  long_holds   = 0;
  // coverage tallies from the predictor
  int  n_writes  = 0;
  int  n_dropped = 0;
  int  n_crc     = 0;
  int  n_bad     = 0;
  int  n_acks    = 0;

  // one framing step: updates the bench state and returns the result word
  function automatic rx_out_t framer_step(input rx_in_t w);
    rx_out_t    r;
    logic [7:0] d;
    logic [8:0] eff;
    r   = '0;
    d   = w.rx_byte;
    // effective limit is the smaller of the register and depth-1
    eff = (int'(pr_limit) > DefaultBufferDepth - 1) ? 9'(DefaultBufferDepth - 1)
                                                     : {1'b0, pr_limit};
    if (w.action == ActTxDone) begin
      // transmission finished only drops back to ready
      pr_phase = PH_READY;
    end else begin
      case (pr_phase)
        PH_CRC_HI: begin
          pr_crc   = {d, 8'h00};
          pr_phase = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          pr_crc   = pr_crc | {8'h00, d};
          pr_phase = PH_DONE;
          n_crc++;
        end
        PH_BUSY: begin
          if (pr_prev != ChDle) begin
            // plain data, dle included, until the buffer limit
            if (pr_count <= eff) begin
              r.write_enable = 1'b1;
              r.write_index  = pr_count[7:0];
              r.write_byte   = d;
              pr_count       = pr_count + 9'd1;
            end else begin
              n_dropped++;
            end
          end else if (d == ChSoh || d == ChStx) begin
            // block start restarts the buffer
            r.write_enable = 1'b1;
            r.write_byte   = d;
            pr_count       = 9'd1;
          end else if (d == pr_seq) begin
            // expected acknowledge: toggle the sequence character
            r.write_enable = 1'b1;
            r.write_byte   = d;
            pr_count       = 9'd1;
            pr_seq         = pr_seq ^ 8'h01;
            pr_phase       = PH_DONE;
            pr_bad         = 1'b0;
            n_acks++;
          end else if (d == ChEtx || d == ChEtb) begin
            // end of block is stored like data, then two crc bytes follow
            if (pr_count <= eff) begin
              r.write_enable = 1'b1;
              r.write_index  = pr_count[7:0];
              r.write_byte   = d;
              pr_count       = pr_count + 9'd1;
            end else begin
              n_dropped++;
            end
            pr_phase = PH_CRC_HI;
          end else if (d != ChSyn) begin
            // any other dle pair, dle dle among them
            pr_phase = PH_DONE;
            pr_bad   = 1'b1;
            n_bad++;
          end
        end
        default: begin
          // ready, done: only eot, enq and dle matter
          if (d == ChEot || d == ChEnq) begin
            r.write_enable = 1'b1;
            r.write_byte   = d;
            pr_count       = 9'd1;
            pr_seq         = AckZero;
            pr_phase       = PH_DONE;
            pr_bad         = 1'b0;
          end else if (d == ChDle) begin
            pr_phase = PH_BUSY;
            pr_count = 9'd0;
          end
        end
      endcase
      pr_prev = d;
    end
    if (r.write_enable) n_writes++;
    r.byte_count   = pr_count;
    r.rx_phase     = pr_phase;
    r.rx_status    = pr_bad;
    r.ack_char     = pr_seq[5:0];
    r.captured_crc = pr_crc;
    return r;
  endfunction

  // hand-written result word for the directed rows
  function automatic rx_out_t result_of(input logic we, input logic [7:0] idx,
                                        input logic [7:0] b, input logic [8:0] cnt,
                                        input phase_e ph, input logic st,
                                        input logic [5:0] ack, input logic [15:0] crc);
    rx_out_t r;
    r.write_enable = we;
    r.write_index  = idx;
    r.write_byte   = b;
    r.byte_count   = cnt;
    r.rx_phase     = ph;
    r.rx_status    = st;
    r.ack_char     = ack;
    r.captured_crc = crc;
    return r;
  endfunction

  task automatic add_row(input logic act, input logic [7:0] b, input logic typed,
                         input rx_out_t want);
    stim_row_t row;
    row.word  = rx_in_t'({act, b});
    row.typed = typed;
    row.want  = want;
    directed_q.push_back(row);
  endtask

  // offer one word, hold it until taken, record its result, maybe idle afterwards
  task automatic send_word(input rx_in_t w, input logic typed, input rx_out_t want);
    rx_out_t predicted;
    int      gap;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = framer_step(w);
    framer_results_q.push_back(typed ? want : predicted);
    words_sent++;
    if (words_sent >= CalmFrom) calm = 1'b1;
    // idle rate changes every few dozen words, zero included
    if (words_sent % 40 == 0) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
    end
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(rx_in_t'({ActByte, b}), 1'b0, '0);
  endtask

  // a well-formed block: dle soh/stx, data, dle etx/etb, two crc bytes
  task automatic send_frame(input int n_data);
    logic [7:0] b;
    send_byte(ChDle);
    send_byte($urandom_range(0, 1) ? ChSoh : ChStx);
    for (int i = 0; i < n_data; i++) begin
      b = ($urandom_range(0, 15) == 0) ? ChDle : 8'($urandom_range(0, 255));
      send_byte(b);
      // a dle in data is only safe when followed by syn
      if (b == ChDle) send_byte(ChSyn);
    end
    send_byte(ChDle);
    send_byte($urandom_range(0, 1) ? ChEtx : ChEtb);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
  endtask

  // random traffic, mostly whole blocks, until the word total reaches upto
  task automatic run_traffic(input int upto, input bit long_first);
    int pick;
    if (long_first) send_frame(260);
    while (words_sent < upto) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(($urandom_range(0, 39) == 0) ? $urandom_range(20, 70)
                                                : $urandom_range(0, 12));
      end else if (pick < 65) begin
        // acknowledge, right or wrong sequence character
        send_byte(ChDle);
        send_byte($urandom_range(0, 1) ? AckOne : AckZero);
      end else if (pick < 75) begin
        send_byte($urandom_range(0, 1) ? ChEot : ChEnq);
      end else if (pick < 80) begin
        send_word(rx_in_t'({ActTxDone, 8'($urandom_range(0, 255))}), 1'b0, '0);
      end else if (pick < 86) begin
        // broken pair
        send_byte(ChDle);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(rx_in_t'({1'($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255))}),
                    1'b0, '0);
      end
    end
  endtask

  // write the limit only once the block has drained
  task automatic set_limit(input logic [7:0] v);
    in_valid <= 1'b0;
    while (framer_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pr_limit  = v;
  endtask

  task automatic check_result(input rx_out_t got);
    rx_out_t want;
    results_seen++;
    if (framer_results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("result word %0d arrived with nothing expected", results_seen);
    end else begin
      want = framer_results_q.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result %0d want: we=%0b idx=%0d byte=%h cnt=%0d ph=%0d st=%0b ack=%h crc=%h",
                   results_seen, want.write_enable, want.write_index, want.write_byte,
                   want.byte_count, want.rx_phase, want.rx_status, want.ack_char,
                   want.captured_crc);
          $display("result %0d got:  we=%0b idx=%0d byte=%h cnt=%0d ph=%0d st=%0b ack=%h crc=%h",
                   results_seen, got.write_enable, got.write_index, got.write_byte,
                   got.byte_count, got.rx_phase, got.rx_status, got.ack_char,
                   got.captured_crc);
        end
      end
    end
  endtask

  // result side: take words, stall in bursts, one long hold on request
  initial begin
    int stall_left;
    int rate;
    int window;
    out_stall  = 1'b0;
    stall_left = 0;
    rate       = 0;
    window     = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result(out_data);
      window++;
      if (window == 64) begin
        window = 0;
        case ($urandom_range(0, 2))
          0:       rate = 0;
          1:       rate = 8;
          default: rate = 30;
        endcase
      end
      if (hold_req) begin
        // long hold so the skid stage fills and the input stalls
        hold_req   = 1'b0;
        stall_left = LongHold;
        long_holds++;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < rate) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: ends the run when no word moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (in_valid && in_stall) input_stalls++;
    end
    $display("watchdog: %0d cycles with no word moving, %0d results outstanding",
             WatchdogLimit, framer_results_q.size());
    $display("dex_ucs_block_receiver regression: fail");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    pr_phase    = PH_READY;
    pr_prev     = 8'h00;
    pr_seq      = AckZero;
    pr_count    = 9'd0;
    pr_bad      = 1'b0;
    pr_crc      = 16'h0000;
    pr_limit    = LimitReset;

    // directed part, run with the limit at its reset value
    // stray byte while ready is ignored
    add_row(ActByte, 8'hFF, 1'b1,
            result_of(1'b0, 8'd0, 8'h00, 9'd0, PH_READY, 1'b0, AckZero[5:0], 16'h0));
    // enquiry from ready
    add_row(ActByte, ChEnq, 1'b1,
            result_of(1'b1, 8'd0, ChEnq, 9'd1, PH_DONE, 1'b0, AckZero[5:0], 16'h0));
    // transmission finished only resets the phase
    add_row(ActTxDone, 8'hAA, 1'b1,
            result_of(1'b0, 8'd0, 8'h00, 9'd1, PH_READY, 1'b0, AckZero[5:0], 16'h0));
    add_row(ActByte, ChEot, 1'b0, '0);
    // block with extreme data, a stored dle and a skipped dle syn
    add_row(ActByte, ChDle, 1'b0, '0);
    add_row(ActByte, ChStx, 1'b0, '0);
    add_row(ActByte, 8'h00, 1'b0, '0);
    add_row(ActByte, 8'hFF, 1'b0, '0);
    add_row(ActByte, ChDle, 1'b0, '0);
    add_row(ActByte, ChSyn, 1'b0, '0);
    add_row(ActByte, ChDle, 1'b0, '0);
    // dle dle is an unknown pair: status bad, phase done
    add_row(ActByte, ChDle, 1'b1,
            result_of(1'b0, 8'd0, 8'h00, 9'd5, PH_DONE, 1'b1, AckZero[5:0], 16'h0));
    // soh block closed by etx and its crc
    add_row(ActByte, ChDle, 1'b0, '0);
    add_row(ActByte, ChSoh, 1'b0, '0);
    add_row(ActByte, ChDle, 1'b0, '0);
    add_row(ActByte, ChEtx, 1'b0, '0);
    add_row(ActByte, 8'hAB, 1'b0, '0);
    add_row(ActByte, 8'hCD, 1'b0, '0);
    // both acknowledges in sequence
    add_row(ActByte, ChDle, 1'b0, '0);
    add_row(ActByte, AckZero, 1'b0, '0);
    add_row(ActByte, ChDle, 1'b0, '0);
    add_row(ActByte, AckOne, 1'b0, '0);
    // etb with an all-ones crc
    add_row(ActByte, ChDle, 1'b0, '0);
    add_row(ActByte, ChEtb, 1'b0, '0);
    add_row(ActByte, 8'hFF, 1'b0, '0);
    add_row(ActByte, 8'hFF, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) send_word(directed_q[i].word, directed_q[i].typed, directed_q[i].want);

    // random phases across a range of limits, each entered with the block drained
    set_limit(8'd0);
    run_traffic(250, 1'b0);
    set_limit(8'd3);
    hold_req = 1'b1;
    run_traffic(450, 1'b0);
    set_limit(8'hFF);
    run_traffic(750, 1'b1);
    set_limit(8'd17);
    run_traffic(900, 1'b0);
    set_limit(8'($urandom_range(4, 254)));
    run_traffic(1050, 1'b0);
    set_limit(8'd1);
    run_traffic(TotalWords, 1'b0);

    // drain, then let the output stage settle
    in_valid <= 1'b0;
    while (framer_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (framer_results_q.size() != 0) fail_count++;

    $display("covered: %0d words, %0d results checked, %0d buffer writes, %0d dropped at limit",
             words_sent, results_seen, n_writes, n_dropped);
    $display("covered: %0d crc captures, %0d bad pairs, %0d acks, %0d input stall cycles, %0d long hold",
             n_crc, n_bad, n_acks, input_stalls, long_holds);
    if (fail_count == 0) begin
      $display("dex_ucs_block_receiver regression: pass");
    end else begin
      $display("dex_ucs_block_receiver regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/ducs_pkg.sv
design/dex_ucs_block_receiver.sv
design/ducs_checker.sv
dv/tb_dex_ucs_block_receiver.sv
